@@ design/ldq_pkg.sv @@
// ----------------------------------------------------------------------------
// Linked descriptor queue manager package
// Field widths, operation and status codes, and the command and status
// bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ldq_pkg;

  localparam int FUNC_W   = 2;
  localparam int QSEL_W   = 2;
  localparam int ENTRY_W  = 8;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 9;

  localparam int QUEUE_NUM = 3;
  localparam logic [QSEL_W-1:0] QUEUE_LIMIT = 2'd3;
  localparam logic [LEN_W-1:0]  COUNT_MAX   = 9'd511;

  // Operation codes; the unused code behaves as a peek
  localparam logic [FUNC_W-1:0] FUNC_PEEK   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_HEAD = 2'd2;

  // How an accepted item is handled
  typedef enum logic [1:0] {
    KIND_RESULT,   // no state change, result ready at once
    KIND_APPEND,   // link at tail, then clear the new entry's link
    KIND_REMOVE    // read the head's link, then advance the head
  } item_kind_t;

  typedef struct packed {
    item_kind_t kind;
    logic       out_free;
  } dp_stat_t;

  typedef struct packed {
    logic emit;        // load result of a non-changing item
    logic append;      // apply append and load its result
    logic fetch;       // capture item, read the head's link
    logic unlink;      // advance the head and load the result
    logic clear_link;  // clear the appended entry's link
  } dp_cmd_t;

endpackage

`default_nettype wire

@@ design/ldq_if.sv @@
// ----------------------------------------------------------------------------
// Linked descriptor queue manager channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ldq_req_if import ldq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [QSEL_W-1:0]   queue_select;
  logic [ENTRY_W-1:0]  entry_index;

  modport source (output valid, func, queue_select, entry_index, input ready);
  modport sink   (input valid, func, queue_select, entry_index, output ready);
endinterface

interface ldq_rsp_if import ldq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                head_valid;
  logic [ENTRY_W-1:0]  head_index;
  logic [LEN_W-1:0]    queue_length;

  modport source (output valid, status, head_valid, head_index, queue_length,
                  input ready);
  modport sink   (input valid, status, head_valid, head_index, queue_length,
                  output ready);
endinterface

`default_nettype wire

@@ design/ldq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Linked descriptor queue manager controller
// Sequences each item through its table read and write steps.
// ----------------------------------------------------------------------------
`default_nettype none

module ldq_ctrl import ldq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_CLEAR
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready = (state == S_IDLE) && stat.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (stat.kind)
            KIND_APPEND: cmd.append = 1'b1;
            KIND_REMOVE: cmd.fetch  = 1'b1;
            default:     cmd.emit   = 1'b1;
          endcase
        end
      end
      S_FETCH: cmd.unlink     = 1'b1;
      S_CLEAR: cmd.clear_link = 1'b1;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && stat.kind == KIND_APPEND) begin
            state <= S_CLEAR;
          end else if (accept && stat.kind == KIND_REMOVE) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: state <= S_IDLE;
        S_CLEAR: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/ldq_datapath.sv @@
// ----------------------------------------------------------------------------
// Linked descriptor queue manager datapath
// Queue head, tail and count registers, the shared next-link table and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ldq_datapath import ldq_pkg::*; #(
  parameter int ENTRY_COUNT = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [FUNC_W-1:0]   func,
  input  logic [QSEL_W-1:0]   queue_select,
  input  logic [ENTRY_W-1:0]  entry_index,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output logic [STATUS_W-1:0] rsp_status,
  output logic                rsp_head_valid,
  output logic [ENTRY_W-1:0]  rsp_head_index,
  output logic [LEN_W-1:0]    rsp_queue_length
);

  localparam int IW = (ENTRY_COUNT > 2) ? $clog2(ENTRY_COUNT) : 1;
  localparam int CW = ((IW > ENTRY_W) ? IW : ENTRY_W) + 1;

  // Queue state
  logic             head_vld [QUEUE_NUM];
  logic [IW-1:0]    head_idx [QUEUE_NUM];
  logic             tail_vld [QUEUE_NUM];
  logic [IW-1:0]    tail_idx [QUEUE_NUM];
  logic [LEN_W-1:0] count    [QUEUE_NUM];

  // Next-link table: valid bit over successor index
  logic [IW:0]      next_link [ENTRY_COUNT];
  logic [IW:0]      link_rd;
  logic             link_we;
  logic [IW-1:0]    link_wa;
  logic [IW:0]      link_wd;

  // Item held across its second step
  logic [QSEL_W-1:0] hold_q;
  logic [IW-1:0]     hold_idx;

  logic                q_ok;
  logic [QSEL_W-1:0]   qsel;
  logic [CW-1:0]       idx_ext;
  logic [IW-1:0]       idx_iw;
  logic                idx_ok;
  logic                head_match;
  logic [STATUS_W-1:0] res_status;
  logic [LEN_W-1:0]    app_len;
  logic [LEN_W-1:0]    dec_len;
  logic                load;

  function automatic logic [ENTRY_W-1:0] to_entry(input logic [IW-1:0] v);
    logic [CW-1:0] e;
    e = CW'(v);
    return e[ENTRY_W-1:0];
  endfunction

  // Decode the offered item against the current queue state
  always_comb begin
    q_ok       = queue_select < QUEUE_LIMIT;
    qsel       = q_ok ? queue_select : '0;
    idx_ext    = CW'(entry_index);
    idx_iw     = idx_ext[IW-1:0];
    idx_ok     = idx_ext < CW'(ENTRY_COUNT);
    head_match = head_vld[qsel] && (CW'(head_idx[qsel]) == idx_ext);
    stat.kind  = KIND_RESULT;
    res_status = ST_DONE;
    if (!q_ok) begin
      res_status = ST_EMPTY;
    end else if (func == FUNC_APPEND) begin
      if (idx_ok) begin
        stat.kind = KIND_APPEND;
      end
    end else if (func == FUNC_REMOVE) begin
      priority if (!tail_vld[qsel]) begin
        res_status = ST_EMPTY;
      end else if (!head_match) begin
        res_status = ST_NOT_HEAD;
      end else begin
        stat.kind = KIND_REMOVE;
      end
    end else begin
      res_status = head_vld[qsel] ? ST_DONE : ST_EMPTY;
    end
    stat.out_free = !rsp_valid || rsp_ready;
  end

  assign app_len = (count[qsel] == COUNT_MAX) ? count[qsel] : count[qsel] + 1'b1;
  assign dec_len = (count[hold_q] == '0) ? count[hold_q] : count[hold_q] - 1'b1;

  // Append writes the old tail's link first; the next cycle clears the new entry's
  assign link_we = (cmd.append && tail_vld[qsel]) || cmd.clear_link;
  assign link_wa = cmd.clear_link ? hold_idx : tail_idx[qsel];
  assign link_wd = cmd.clear_link ? '0 : {1'b1, idx_iw};

  always_ff @(posedge clk) begin
    if (link_we) begin
      next_link[link_wa] <= link_wd;
    end
    if (cmd.fetch) begin
      link_rd <= next_link[idx_iw];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append || cmd.fetch) begin
      hold_q   <= qsel;
      hold_idx <= idx_iw;
    end
  end

  // Queue control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUEUE_NUM; i++) begin
        head_vld[i] <= 1'b0;
        tail_vld[i] <= 1'b0;
        count[i]    <= '0;
      end
    end else if (cmd.append) begin
      head_vld[qsel] <= 1'b1;
      tail_vld[qsel] <= 1'b1;
      count[qsel]    <= app_len;
    end else if (cmd.unlink) begin
      head_vld[hold_q] <= link_rd[IW];
      if (tail_idx[hold_q] == hold_idx) begin
        tail_vld[hold_q] <= 1'b0;
      end
      count[hold_q] <= dec_len;
    end
  end

  // Queue head and tail indices
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      if (!head_vld[qsel]) begin
        head_idx[qsel] <= idx_iw;
      end
      tail_idx[qsel] <= idx_iw;
    end else if (cmd.unlink && link_rd[IW]) begin
      head_idx[hold_q] <= link_rd[IW-1:0];
    end
  end

  // Result register
  assign load = cmd.emit || cmd.append || cmd.unlink;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Hold the result fields between loads
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      rsp_status       <= ST_DONE;
      rsp_head_valid   <= 1'b1;
      rsp_head_index   <= head_vld[qsel] ? to_entry(head_idx[qsel]) : entry_index;
      rsp_queue_length <= app_len;
    end else if (cmd.unlink) begin
      rsp_status       <= ST_DONE;
      rsp_head_valid   <= link_rd[IW];
      rsp_head_index   <= link_rd[IW] ? to_entry(link_rd[IW-1:0]) : '0;
      rsp_queue_length <= dec_len;
    end else if (cmd.emit) begin
      rsp_status       <= res_status;
      rsp_head_valid   <= q_ok && head_vld[qsel];
      rsp_head_index   <= (q_ok && head_vld[qsel]) ? to_entry(head_idx[qsel]) : '0;
      rsp_queue_length <= q_ok ? count[qsel] : '0;
    end
  end

endmodule

`default_nettype wire

@@ design/linked_descriptor_queue_manager_unit.sv @@
// ----------------------------------------------------------------------------
// Linked descriptor queue manager
// Three FIFO queues threaded through one shared next-link table.
// ----------------------------------------------------------------------------
// Each request names a queue (free, allocated, send) and an operation: peek
// the head, append an entry at the tail, or remove a named entry, which only
// happens if it is the current head. Every request gives one response with
// a status (done, queue empty, not head) and the selected queue's head and
// count after the operation. Requests are taken one at a time. A peek, a
// request on the unused queue selector, an out-of-range append and a
// rejected remove load their response when taken; an append links from the
// old tail, then clears the new entry's link, and a successful remove reads
// the head's link, then advances the head, each split set by the single
// write port and registered read of the link table. A request is
// taken only while the response register is empty or its transfer completes
// in the same cycle. Appending an entry that is already linked is not
// checked and may corrupt the queues. The link table has no reset.
`default_nettype none

module linked_descriptor_queue_manager_unit import ldq_pkg::*; #(
  parameter int ENTRY_COUNT = 256
) (
  input  logic      clk,
  input  logic      rst,
  ldq_req_if.sink   req,
  ldq_rsp_if.source rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  // Controller: one request in flight, steps through read and write phases
  ldq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign req.ready = in_ready;

  // Datapath: queue registers, link table and the response register
  ldq_datapath #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .func             (req.func),
    .queue_select     (req.queue_select),
    .entry_index      (req.entry_index),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_head_valid   (rsp.head_valid),
    .rsp_head_index   (rsp.head_index),
    .rsp_queue_length (rsp.queue_length)
  );

endmodule

`default_nettype wire
